// ===== sv/sbhp_pkg.sv =====
// shared types and constants of the shader blob header parser
package sbhp_pkg;

  // result status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBadSig   = 3'd1;
  localparam logic [2:0] StatusBadStage = 3'd2;
  localparam logic [2:0] StatusTrunc    = 3'd3;
  localparam logic [2:0] StatusZeroSize = 3'd4;
  localparam logic [2:0] StatusOverrun  = 3'd5;
  localparam logic [2:0] StatusTooLong  = 3'd6;

  // stage codes
  localparam logic [1:0] StageFrag    = 2'd0;
  localparam logic [1:0] StageVertex  = 2'd1;
  localparam logic [1:0] StageCompute = 2'd2;

  // magic letters
  localparam logic [7:0] CharS = 8'h53;
  localparam logic [7:0] CharH = 8'h48;
  localparam logic [7:0] CharF = 8'h46;
  localparam logic [7:0] CharV = 8'h56;
  localparam logic [7:0] CharC = 8'h43;

  // format versions that add header fields
  localparam logic [7:0] VerHashOut = 8'd6;
  localparam logic [7:0] VerTexInfo = 8'd8;
  localparam logic [7:0] VerTexFmt  = 8'd10;

  // parse phases
  typedef enum logic [3:0] {
    PhMagic    = 4'd0,
    PhHashIn   = 4'd1,
    PhHashOut  = 4'd2,
    PhUCount   = 4'd3,
    PhNameLen  = 4'd4,
    PhName     = 4'd5,
    PhUType    = 4'd6,
    PhUReg     = 4'd7,
    PhTexInfo  = 4'd8,
    PhTexFmt   = 4'd9,
    PhCodeSize = 4'd10,
    PhPayload  = 4'd11
  } phase_e;

  // packed result word, lowest field last
  typedef struct packed {
    logic [31:0] code_size;
    logic [31:0] code_offset;
    logic [7:0]  version;
    logic [1:0]  stage;
    logic [2:0]  status;
  } result_t;

endpackage

// ===== sv/shader_blob_header_parser.sv =====
// shader blob header parser top level
//
// Takes a shader blob one word (byte) per handshake, with tlast on the final byte, and
// gives one result word when the final byte is taken: status, stage, version, code
// offset and code size. Each byte is handled in the cycle it is accepted, so the block
// takes one byte per cycle; the only stall comes from the single output register:
// while a result waits for the master side to take it, no further byte is accepted.
// The result word is valid the cycle after its final byte. Byte offsets are counted
// in OFFSET_BITS bits; a byte that arrives once the counter is full flags the blob as
// too long. The first error of a blob is kept, and the parser returns to its reset
// state after each final byte.
module shader_blob_header_parser #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [2:0], stage [4:3], version [12:5], code_offset [44:13],
  // code_size [76:45], zero fill [79:77]
  output logic [79:0] m_axis_tdata
);

  localparam logic [OFFSET_BITS-1:0] CountMax = '1;

  // parser state
  sbhp_pkg::phase_e       phase_q, phase_d;
  logic [1:0]             idx_q, idx_d;
  logic [31:0]            acc_q, acc_d;
  logic [7:0]             ver_q, ver_d;
  logic [1:0]             stage_q, stage_d;
  logic [15:0]            uleft_q, uleft_d;
  logic [7:0]             nleft_q, nleft_d;
  logic [OFFSET_BITS-1:0] seen_q, seen_d;
  logic [31:0]            psize_q, psize_d;
  logic [31:0]            pleft_q, pleft_d;
  logic [OFFSET_BITS-1:0] cstart_q, cstart_d;
  logic [2:0]             err_q, err_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  sbhp_pkg::result_t      res_q, res_d;

  logic                   in_acc;
  logic [31:0]            field_val;
  logic [1:0]             idx_inc;
  logic                   gather_en;
  logic                   gather_two;
  logic                   field_done;
  logic [15:0]            uleft_dec;
  logic [7:0]             nleft_dec;
  logic [2:0]             res_status;
  logic [63:0]            cstart_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

  // field gathering, little endian
  assign field_val = acc_q | (32'(s_axis_tdata) << {idx_q, 3'b000});
  assign idx_inc   = idx_q + 2'd1;
  assign uleft_dec = uleft_q - 16'd1;
  assign nleft_dec = nleft_q - 8'd1;

  always_comb begin
    gather_en  = 1'b0;
    gather_two = 1'b0;
    case (phase_q)
      sbhp_pkg::PhMagic, sbhp_pkg::PhHashIn, sbhp_pkg::PhHashOut,
      sbhp_pkg::PhUReg, sbhp_pkg::PhCodeSize: begin
        gather_en = 1'b1;
      end
      sbhp_pkg::PhUCount, sbhp_pkg::PhUType, sbhp_pkg::PhTexInfo,
      sbhp_pkg::PhTexFmt: begin
        gather_en  = 1'b1;
        gather_two = 1'b1;
      end
      default: begin
        gather_en = 1'b0;
      end
    endcase
  end

  assign field_done = gather_en && (gather_two ? (idx_inc == 2'd2) : (idx_inc == 2'd0));

  // per byte state update and result
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    ver_d       = ver_q;
    stage_d     = stage_q;
    uleft_d     = uleft_q;
    nleft_d     = nleft_q;
    seen_d      = seen_q;
    psize_d     = psize_q;
    pleft_d     = pleft_q;
    cstart_d    = cstart_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    res_d       = res_q;
    res_status  = sbhp_pkg::StatusOk;
    cstart_ext  = '0;

    if (in_acc && err_q == sbhp_pkg::StatusOk) begin
      if (seen_q == CountMax) begin
        err_d = sbhp_pkg::StatusTooLong;
      end else begin
        seen_d = seen_q + 1'b1;
        if (gather_en) begin
          if (field_done) begin
            acc_d = '0;
            idx_d = '0;
          end else begin
            acc_d = field_val;
            idx_d = idx_inc;
          end
        end
        case (phase_q)
          sbhp_pkg::PhMagic: begin
            if (field_done) begin
              if (field_val[15:8] != sbhp_pkg::CharS || field_val[23:16] != sbhp_pkg::CharH)
              begin
                err_d = sbhp_pkg::StatusBadSig;
              end else if (field_val[7:0] == sbhp_pkg::CharF) begin
                stage_d = sbhp_pkg::StageFrag;
                ver_d   = field_val[31:24];
                phase_d = sbhp_pkg::PhHashIn;
              end else if (field_val[7:0] == sbhp_pkg::CharV) begin
                stage_d = sbhp_pkg::StageVertex;
                ver_d   = field_val[31:24];
                phase_d = sbhp_pkg::PhHashIn;
              end else if (field_val[7:0] == sbhp_pkg::CharC) begin
                stage_d = sbhp_pkg::StageCompute;
                ver_d   = field_val[31:24];
                phase_d = sbhp_pkg::PhHashIn;
              end else begin
                err_d = sbhp_pkg::StatusBadStage;
              end
            end
          end
          sbhp_pkg::PhHashIn: begin
            if (field_done) begin
              phase_d = (ver_q >= sbhp_pkg::VerHashOut) ? sbhp_pkg::PhHashOut
                                                        : sbhp_pkg::PhUCount;
            end
          end
          sbhp_pkg::PhHashOut: begin
            if (field_done) begin
              phase_d = sbhp_pkg::PhUCount;
            end
          end
          sbhp_pkg::PhUCount: begin
            if (field_done) begin
              uleft_d = field_val[15:0];
              phase_d = (field_val[15:0] == 16'd0) ? sbhp_pkg::PhCodeSize
                                                   : sbhp_pkg::PhNameLen;
            end
          end
          sbhp_pkg::PhNameLen: begin
            nleft_d = s_axis_tdata;
            phase_d = (s_axis_tdata == 8'd0) ? sbhp_pkg::PhUType : sbhp_pkg::PhName;
          end
          sbhp_pkg::PhName: begin
            nleft_d = nleft_dec;
            if (nleft_dec == 8'd0) begin
              phase_d = sbhp_pkg::PhUType;
            end
          end
          sbhp_pkg::PhUType: begin
            if (field_done) begin
              phase_d = sbhp_pkg::PhUReg;
            end
          end
          sbhp_pkg::PhUReg, sbhp_pkg::PhTexInfo, sbhp_pkg::PhTexFmt: begin
            if (field_done) begin
              if (phase_q == sbhp_pkg::PhUReg && ver_q >= sbhp_pkg::VerTexInfo) begin
                phase_d = sbhp_pkg::PhTexInfo;
              end else if (phase_q == sbhp_pkg::PhTexInfo && ver_q >= sbhp_pkg::VerTexFmt)
              begin
                phase_d = sbhp_pkg::PhTexFmt;
              end else begin
                // end of one uniform entry
                uleft_d = uleft_dec;
                phase_d = (uleft_dec == 16'd0) ? sbhp_pkg::PhCodeSize : sbhp_pkg::PhNameLen;
              end
            end
          end
          sbhp_pkg::PhCodeSize: begin
            if (field_done) begin
              if (field_val == 32'd0) begin
                err_d = sbhp_pkg::StatusZeroSize;
              end else begin
                psize_d  = field_val;
                pleft_d  = field_val;
                cstart_d = seen_q + 1'b1;
                phase_d  = sbhp_pkg::PhPayload;
              end
            end
          end
          sbhp_pkg::PhPayload: begin
            // count down code bytes still owed
            if (pleft_q != 32'd0) begin
              pleft_d = pleft_q - 32'd1;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    // result on the final byte, then back to reset
    if (in_acc && s_axis_tlast) begin
      res_status = err_d;
      if (res_status == sbhp_pkg::StatusOk && phase_d != sbhp_pkg::PhPayload) begin
        res_status = sbhp_pkg::StatusTrunc;
      end
      if (res_status == sbhp_pkg::StatusOk && pleft_d != 32'd0) begin
        res_status = sbhp_pkg::StatusOverrun;
      end
      cstart_ext        = 64'(cstart_d);
      out_valid_d       = 1'b1;
      res_d.status      = res_status;
      res_d.stage       = stage_d;
      res_d.version     = ver_d;
      res_d.code_offset = (res_status == sbhp_pkg::StatusOk) ? cstart_ext[31:0] : 32'd0;
      res_d.code_size   = (res_status == sbhp_pkg::StatusOk) ? psize_d : 32'd0;

      phase_d  = sbhp_pkg::PhMagic;
      idx_d    = '0;
      acc_d    = '0;
      ver_d    = '0;
      stage_d  = '0;
      uleft_d  = '0;
      nleft_d  = '0;
      seen_d   = '0;
      psize_d  = '0;
      pleft_d  = '0;
      cstart_d = '0;
      err_d    = sbhp_pkg::StatusOk;
    end
  end

  // control and parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sbhp_pkg::PhMagic;
      idx_q       <= '0;
      acc_q       <= '0;
      ver_q       <= '0;
      stage_q     <= '0;
      uleft_q     <= '0;
      nleft_q     <= '0;
      seen_q      <= '0;
      psize_q     <= '0;
      pleft_q     <= '0;
      cstart_q    <= '0;
      err_q       <= sbhp_pkg::StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      ver_q       <= ver_d;
      stage_q     <= stage_d;
      uleft_q     <= uleft_d;
      nleft_q     <= nleft_d;
      seen_q      <= seen_d;
      psize_q     <= psize_d;
      pleft_q     <= pleft_d;
      cstart_q    <= cstart_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // a final byte always returns the parser to its reset state
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (phase_q == sbhp_pkg::PhMagic && seen_q == '0 &&
                                 err_q == sbhp_pkg::StatusOk))
    else $error("parser not reset after final byte");

  // a latched error holds until the final byte
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != sbhp_pkg::StatusOk && !(in_acc && s_axis_tlast)) |=> $stable(err_q))
    else $error("latched error changed mid blob");

  // a new result appears only after a final byte
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && s_axis_tlast))
    else $error("result without final byte");

  // ok results carry a nonzero code size
  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == sbhp_pkg::StatusOk) |-> (res_q.code_size != 32'd0))
    else $error("ok result with zero code size");

  // the payload phase always has a code size
  a_payload_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sbhp_pkg::PhPayload) |-> (psize_q != 32'd0 && pleft_q <= psize_q))
    else $error("payload phase without code size");

endmodule
